// ===== design/fastq_record_parser_top_macros.svh =====
// Assertion macros used by the FASTQ record parser checker.
`ifndef FASTQ_RECORD_PARSER_TOP_MACROS_SVH
`define FASTQ_RECORD_PARSER_TOP_MACROS_SVH

// check a property while reset is low
`define FRP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every edge, reset included
`define FRP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/frp_pkg.sv =====
// Shared constants and codes of the FASTQ record parser.
`default_nettype none
package frp_pkg;

   localparam int FRP_LENGTH_BITS = 16;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2,
      KIND_DROP = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      FIELD_NAME    = 2'd0,
      FIELD_COMMENT = 2'd1,
      FIELD_SEQ     = 2'd2,
      FIELD_QUAL    = 2'd3
   } field_type;

endpackage
`default_nettype wire

// ===== design/fastq_record_parser_top.sv =====
// FASTQ record parser: splits a text byte stream into record fields.
//
// Input channel req_*: one text byte (req_byte_value) or an end-of-input
// marker (req_end_of_input) per transfer. Result channel rsp_*: one result per
// transfer (field byte, field end with length, record complete or record
// discarded); rsp_last marks the final result caused by one input transfer.
// An input transfer updates the parse state and loads all its results (zero to
// four) into a four-entry result buffer in the same cycle; the first result is
// offered on the next cycle.
// Throughput is one input per cycle while each input yields at most one result
// and rsp_ready is high. An input that yields more than one result holds the
// input channel while the result buffer drains one entry per cycle, when the
// receiver is ready; a new input is taken in the cycle its last entry leaves.
// When the receiver stalls, the buffer holds and req_ready drops once its last
// entry is waiting. Synchronous reset empties the buffer and returns the
// parser to idle, between records.
`default_nettype none
module fastq_record_parser_top #(
   parameter int LENGTH_BITS = frp_pkg::FRP_LENGTH_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [1:0]       rsp_field,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_field_length,
   output logic             rsp_last
);
   import frp_pkg::*;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_TWO   = 8'h32;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_SKIP    = 3'd1,
      PH_NAME    = 3'd2,
      PH_COMMENT = 3'd3,
      PH_SEQ     = 3'd4,
      PH_QUAL    = 3'd5
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      field_type   field;
      logic [7:0]  data;
      logic [15:0] length;
      logic        last;
   } result_type;

   function automatic result_type make_res(input kind_type k, input field_type f,
                                           input logic [7:0] d, input logic [15:0] n);
      result_type r;
      r.kind   = k;
      r.field  = f;
      r.data   = d;
      r.length = n;
      r.last   = 1'b0;
      return r;
   endfunction

   function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
      return (&v) ? v : v + LENGTH_BITS'(1);
   endfunction

   phase_type              phase_ff, phase_in;
   logic [7:0]             hold_ff [3];
   logic [7:0]             hold_in [3];
   logic [1:0]             hcnt_ff, hcnt_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   sep_ff, sep_in;
   result_type             buf_ff [4];
   result_type             res_list [4];
   logic [2:0]             res_n;
   logic [2:0]             cnt_ff, cnt_in;
   logic [1:0]             rd_ff, rd_in;

   logic       req_xfer;
   logic       rsp_xfer;
   logic [7:0] b;
   logic       name_done;
   logic       name_cr;
   logic [1:0] name_kept;
   logic       name_strip;

   assign b         = req_byte_value;
   assign req_ready = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_ready);
   assign rsp_valid = (cnt_ff != 3'd0);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   assign rsp_kind         = buf_ff[rd_ff].kind;
   assign rsp_field        = buf_ff[rd_ff].field;
   assign rsp_data_byte    = buf_ff[rd_ff].data;
   assign rsp_field_length = buf_ff[rd_ff].length;
   assign rsp_last         = buf_ff[rd_ff].last;

   assign name_done = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF);

   always_comb begin
      case (hcnt_ff)
         2'd1:    name_cr = (hold_ff[0] == CH_CR);
         2'd2:    name_cr = (hold_ff[1] == CH_CR);
         2'd3:    name_cr = (hold_ff[2] == CH_CR);
         default: name_cr = 1'b0;
      endcase
      name_kept  = hcnt_ff - 2'(name_cr);
      name_strip = (name_kept == 2'd2) && (len_ff != '0) && (hold_ff[0] == CH_SLASH) &&
                   ((hold_ff[1] == CH_ONE) || (hold_ff[1] == CH_TWO));
   end

   always_comb begin
      phase_in = phase_ff;
      hold_in  = hold_ff;
      hcnt_in  = hcnt_ff;
      len_in   = len_ff;
      sep_in   = sep_ff;
      res_n    = 3'd0;
      for (int i = 0; i < 4; i++) begin
         res_list[i] = '0;
      end

      if (req_end_of_input) begin
         if ((phase_ff == PH_QUAL) && sep_ff && ((len_ff != '0) || (hcnt_ff != 2'd0))) begin
            res_list[0] = make_res(KIND_END, FIELD_QUAL, 8'd0, 16'(len_ff));
            res_list[1] = make_res(KIND_DONE, FIELD_NAME, 8'd0, 16'd0);
            res_n       = 3'd2;
         end else if (phase_ff inside {[PH_NAME:PH_QUAL]}) begin
            res_list[0] = make_res(KIND_DROP, FIELD_NAME, 8'd0, 16'd0);
            res_n       = 3'd1;
         end
         phase_in = PH_IDLE;
         hcnt_in  = 2'd0;
         len_in   = '0;
         sep_in   = 1'b0;
      end else begin
         case (phase_ff)
            PH_SKIP: begin
               if (b == CH_LF) phase_in = PH_IDLE;
            end
            PH_NAME: begin
               if (name_done) begin
                  if ((name_kept != 2'd0) && !name_strip) begin
                     res_list[res_n[1:0]] = make_res(KIND_BYTE, FIELD_NAME, hold_ff[0], 16'd0);
                     res_n  = res_n + 3'd1;
                     len_in = sat_inc(len_in);
                  end
                  if ((name_kept >= 2'd2) && !name_strip) begin
                     res_list[res_n[1:0]] = make_res(KIND_BYTE, FIELD_NAME, hold_ff[1], 16'd0);
                     res_n  = res_n + 3'd1;
                     len_in = sat_inc(len_in);
                  end
                  res_list[res_n[1:0]] = make_res(KIND_END, FIELD_NAME, 8'd0, 16'(len_in));
                  res_n   = res_n + 3'd1;
                  len_in  = '0;
                  hcnt_in = 2'd0;
                  if (b == CH_LF) begin
                     res_list[res_n[1:0]] = make_res(KIND_END, FIELD_COMMENT, 8'd0, 16'd0);
                     res_n    = res_n + 3'd1;
                     phase_in = PH_SEQ;
                  end else begin
                     phase_in = PH_COMMENT;
                  end
               end else if (b == CH_CR) begin
                  case (hcnt_ff)
                     2'd3: begin
                        res_list[0] = make_res(KIND_BYTE, FIELD_NAME, hold_ff[0], 16'd0);
                        res_n       = 3'd1;
                        len_in      = sat_inc(len_in);
                        hold_in[0]  = hold_ff[1];
                        hold_in[1]  = hold_ff[2];
                        hold_in[2]  = b;
                     end
                     2'd2:    hold_in[2] = b;
                     2'd1:    hold_in[1] = b;
                     default: hold_in[0] = b;
                  endcase
                  hcnt_in = (hcnt_ff == 2'd3) ? 2'd3 : hcnt_ff + 2'd1;
               end else begin
                  case (hcnt_ff)
                     2'd3: begin
                        res_list[0] = make_res(KIND_BYTE, FIELD_NAME, hold_ff[0], 16'd0);
                        res_list[1] = make_res(KIND_BYTE, FIELD_NAME, hold_ff[1], 16'd0);
                        res_n       = 3'd2;
                        len_in      = sat_inc(sat_inc(len_in));
                        hold_in[0]  = hold_ff[2];
                        hold_in[1]  = b;
                     end
                     2'd2: begin
                        res_list[0] = make_res(KIND_BYTE, FIELD_NAME, hold_ff[0], 16'd0);
                        res_n       = 3'd1;
                        len_in      = sat_inc(len_in);
                        hold_in[0]  = hold_ff[1];
                        hold_in[1]  = b;
                     end
                     2'd1:    hold_in[1] = b;
                     default: hold_in[0] = b;
                  endcase
                  hcnt_in = (hcnt_ff == 2'd0) ? 2'd1 : 2'd2;
               end
            end
            PH_COMMENT, PH_SEQ, PH_QUAL: begin
               if ((phase_ff == PH_QUAL) && !sep_ff) begin
                  if (b == CH_LF) sep_in = 1'b1;
               end else if (b == CH_LF) begin
                  case (phase_ff)
                     PH_COMMENT: begin
                        res_list[0] = make_res(KIND_END, FIELD_COMMENT, 8'd0, 16'(len_ff));
                        res_n       = 3'd1;
                        phase_in    = PH_SEQ;
                     end
                     PH_SEQ: begin
                        res_list[0] = make_res(KIND_END, FIELD_SEQ, 8'd0, 16'(len_ff));
                        res_n       = 3'd1;
                        phase_in    = PH_QUAL;
                        sep_in      = 1'b0;
                     end
                     default: begin
                        res_list[0] = make_res(KIND_END, FIELD_QUAL, 8'd0, 16'(len_ff));
                        res_list[1] = make_res(KIND_DONE, FIELD_NAME, 8'd0, 16'd0);
                        res_n       = 3'd2;
                        phase_in    = PH_IDLE;
                        sep_in      = 1'b0;
                     end
                  endcase
                  len_in  = '0;
                  hcnt_in = 2'd0;
               end else begin
                  if (hcnt_ff != 2'd0) begin
                     res_list[0] = make_res(KIND_BYTE, field_type'(2'(phase_ff - PH_NAME)),
                                            CH_CR, 16'd0);
                     res_n       = 3'd1;
                     len_in      = sat_inc(len_in);
                  end
                  if (b == CH_CR) begin
                     hcnt_in = 2'd1;
                  end else begin
                     res_list[res_n[1:0]] = make_res(KIND_BYTE,
                                                     field_type'(2'(phase_ff - PH_NAME)),
                                                     b, 16'd0);
                     res_n   = res_n + 3'd1;
                     len_in  = sat_inc(len_in);
                     hcnt_in = 2'd0;
                  end
               end
            end
            default: begin
               if ((b == CH_LF) || (b == CH_CR)) begin
                  phase_in = PH_IDLE;
               end else if (b == CH_AT) begin
                  phase_in = PH_NAME;
                  hcnt_in  = 2'd0;
                  len_in   = '0;
                  sep_in   = 1'b0;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         endcase
      end

      for (int i = 0; i < 4; i++) begin
         res_list[i].last = (3'(i) + 3'd1 == res_n);
      end
   end

   assign cnt_in = req_xfer ? res_n : cnt_ff - 3'(rsp_xfer);
   assign rd_in  = req_xfer ? 2'd0 : rd_ff + 2'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hcnt_ff  <= 2'd0;
         len_ff   <= '0;
         sep_ff   <= 1'b0;
         cnt_ff   <= 3'd0;
         rd_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         if (req_xfer) begin
            phase_ff <= phase_in;
            hcnt_ff  <= hcnt_in;
            len_ff   <= len_in;
            sep_ff   <= sep_in;
            hold_ff  <= hold_in;
            buf_ff   <= res_list;
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/frp_checker.sv =====
// Port-level checks of the FASTQ record parser, bound to its top level.
`default_nettype none
`include "fastq_record_parser_top_macros.svh"
module frp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [1:0]  rsp_field,
   input wire logic [7:0]  rsp_data_byte,
   input wire logic [15:0] rsp_field_length,
   input wire logic        rsp_last
);
   import frp_pkg::*;

   `FRP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result pending after reset")
   `FRP_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_field_length) && $stable(rsp_last)), "stalled result changed")
   `FRP_ASSERT(a_marker_data, clock, reset, (rsp_valid && rsp_kind != KIND_BYTE) |-> (rsp_data_byte == 8'd0), "marker carries a data byte")
   `FRP_ASSERT(a_byte_length, clock, reset, (rsp_valid && rsp_kind == KIND_BYTE) |-> (rsp_field_length == 16'd0 && !($past(rsp_valid) && $past(rsp_kind) == KIND_DONE && !$past(rsp_last) && $past(rsp_ready))), "field byte carries a length")
   `FRP_ASSERT(a_record_marker, clock, reset, (rsp_valid && (rsp_kind == KIND_DONE || rsp_kind == KIND_DROP)) |-> (rsp_field == FIELD_NAME && rsp_field_length == 16'd0 && rsp_last), "record marker malformed")

endmodule

bind fastq_record_parser_top frp_checker u_frp_checker (.*);
`default_nettype wire
